FILE: hdl/cwsb_pkg.sv
// Shared types and constants for the 24-hour clock with set buttons.
package cwsb_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO    = 2'd0,
        CFG_LOCKOUT = 2'd1,
        CFG_STEP    = 2'd2,
        CFG_DARK    = 2'd3
    } t_cfg_idx;

    localparam logic [4:0] TENTHS_PER_SEC = 5'd10;
    localparam logic [6:0] SECS_PER_MIN   = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [5:0] MIN_LAST       = 6'd59;
    localparam logic [4:0] HOUR_LAST      = 5'd23;
    localparam logic [7:0] FULL_BRIGHT    = 8'd255;

    localparam logic       RST_AUTO    = 1'b0;
    localparam logic [3:0] RST_LOCKOUT = 4'd5;
    localparam logic [7:0] RST_STEP    = 8'd16;
    localparam logic [7:0] RST_DARK    = 8'd100;

    localparam int unsigned BTN_BRIGHT    = 0;
    localparam int unsigned BTN_VIEW      = 1;
    localparam int unsigned BTN_MIN_UP    = 2;
    localparam int unsigned BTN_MIN_DOWN  = 3;
    localparam int unsigned BTN_HOUR_UP   = 4;
    localparam int unsigned BTN_HOUR_DOWN = 5;

    typedef struct packed {
        logic [7:0] light_level;
        logic [5:0] buttons;
    } t_in_word;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [7:0] brightness_out;
        logic       light_view;
        logic       temperature_request;
        logic       second_elapsed;
    } t_out_word;

    typedef struct packed {
        logic       auto_brightness;
        logic [3:0] lockout_ticks;
        logic [7:0] brightness_step;
        logic [7:0] dark_threshold;
    } t_cfg;

endpackage

FILE: hdl/clock_with_set_buttons.sv
// Top level of the 24-hour clock with set buttons: input and result registers.
//
// channel | direction | handshake                 | word
// --------+-----------+---------------------------+-----------------------------
// tick in | in        | i_in_valid / o_in_stall   | light_level, buttons
// result  | out       | o_out_valid / i_out_stall | time, brightness, view, flags
// config  | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the result side does not stall; an accepted tick goes
// through the input register, then the update logic, into the result register.
// The result register frees as it is taken, so input runs on while output drains.
// Synchronous active-low reset clears the time, lockout, brightness and view,
// and loads the configuration defaults.
module clock_with_set_buttons import cwsb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_word  r_in;
    logic      r_in_vld;
    t_out_word r_out;
    logic      r_out_vld;
    t_cfg      cfg;
    t_out_word res;
    logic      out_free;
    logic      step;
    logic      in_take;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    cwsb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cwsb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_in    (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

FILE: hdl/cwsb_cfg.sv
// Configuration register bank for the 24-hour clock.
module cwsb_cfg import cwsb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_brightness <= RST_AUTO;
            r_cfg.lockout_ticks   <= RST_LOCKOUT;
            r_cfg.brightness_step <= RST_STEP;
            r_cfg.dark_threshold  <= RST_DARK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AUTO:    r_cfg.auto_brightness <= i_cfg_data[0];
                CFG_LOCKOUT: r_cfg.lockout_ticks   <= i_cfg_data[3:0];
                CFG_STEP:    r_cfg.brightness_step <= i_cfg_data;
                CFG_DARK:    r_cfg.dark_threshold  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/cwsb_core.sv
// Clock state and per-tick update logic: time, brightness, view and lockout.
module cwsb_core import cwsb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_in,
    input  t_cfg      i_cfg,
    output t_out_word o_res
);

    logic [3:0] r_tenth, n_tenth;
    logic [5:0] r_sec,   n_sec;
    logic [5:0] r_min,   n_min;
    logic [4:0] r_hour,  n_hour;
    logic [3:0] r_lock,  n_lock;
    logic [7:0] r_bright, n_bright;
    logic       r_view,  n_view;

    logic [4:0] tenth_inc;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic       sec_done;
    logic       temp_req;

    assign tenth_inc = {1'b0, r_tenth} + 5'd1;
    assign sec_inc   = {1'b0, r_sec} + 7'd1;
    assign min_inc   = {1'b0, r_min} + 7'd1;
    assign hour_inc  = {1'b0, r_hour} + 6'd1;
    assign sec_done  = (tenth_inc >= TENTHS_PER_SEC);

    always_comb begin
        n_tenth  = sec_done ? 4'd0 : tenth_inc[3:0];
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_lock   = r_lock;
        n_bright = r_bright;
        n_view   = r_view;
        temp_req = 1'b0;

        // advance one second, then sample light when auto brightness is on
        if (sec_done) begin
            if (sec_inc >= SECS_PER_MIN) begin
                n_sec = 6'd0;
                if (min_inc >= MINS_PER_HOUR) begin
                    n_min  = 6'd0;
                    n_hour = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc[4:0];
                end else begin
                    n_min = min_inc[5:0];
                end
            end else begin
                n_sec = sec_inc[5:0];
            end
            if (i_cfg.auto_brightness) begin
                if (i_in.light_level <= i_cfg.dark_threshold) begin
                    n_bright = FULL_BRIGHT;
                end else begin
                    n_bright = FULL_BRIGHT - i_in.light_level + i_cfg.dark_threshold;
                end
            end
        end

        // lockout countdown, or else buttons in bit order
        if (r_lock != 4'd0) begin
            n_lock = r_lock - 4'd1;
        end else begin
            if (i_in.buttons != 6'd0) begin
                n_lock = i_cfg.lockout_ticks;
            end
            if (i_in.buttons[BTN_BRIGHT]) begin
                if (i_cfg.auto_brightness) begin
                    temp_req = 1'b1;
                end else begin
                    n_bright = n_bright + i_cfg.brightness_step;
                end
            end
            if (i_in.buttons[BTN_VIEW]) begin
                n_view = ~n_view;
            end
            if (i_in.buttons[BTN_MIN_UP]) begin
                n_sec = 6'd0;
                n_min = (n_min >= MIN_LAST) ? 6'd0 : n_min + 6'd1;
            end
            if (i_in.buttons[BTN_MIN_DOWN]) begin
                n_sec = 6'd0;
                if (n_min == 6'd0 || n_min > MIN_LAST) begin
                    n_min = MIN_LAST;
                end else begin
                    n_min = n_min - 6'd1;
                end
            end
            if (i_in.buttons[BTN_HOUR_UP]) begin
                n_sec  = 6'd0;
                n_hour = (n_hour >= HOUR_LAST) ? 5'd0 : n_hour + 5'd1;
            end
            if (i_in.buttons[BTN_HOUR_DOWN]) begin
                n_sec = 6'd0;
                if (n_hour == 5'd0 || n_hour > HOUR_LAST) begin
                    n_hour = HOUR_LAST;
                end else begin
                    n_hour = n_hour - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenth  <= 4'd0;
            r_sec    <= 6'd0;
            r_min    <= 6'd0;
            r_hour   <= 5'd0;
            r_lock   <= 4'd0;
            r_bright <= 8'd0;
            r_view   <= 1'b0;
        end else if (i_step) begin
            r_tenth  <= n_tenth;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_lock   <= n_lock;
            r_bright <= n_bright;
            r_view   <= n_view;
        end
    end

    assign o_res.hours               = n_hour;
    assign o_res.minutes             = n_min;
    assign o_res.seconds             = n_sec;
    assign o_res.brightness_out      = n_bright;
    assign o_res.light_view          = n_view;
    assign o_res.temperature_request = temp_req;
    assign o_res.second_elapsed      = sec_done;

endmodule
